### rtl/core/rfft_pkg.sv
// Shared types, codes and twiddle-table functions for the radix-2 real FFT block.
// No dependencies; imported by every module of the block.
package rfft_pkg;

    localparam int IN_W        = 36;
    localparam int OUT_W       = 48;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int LOG2_MIN    = 2;
    localparam logic [3:0] LOG2_RESET = 4'd10;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOG2_SIZE    = 1'd1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic                   func;
        logic signed [IN_W-1:0] sample_re;
        logic signed [IN_W-1:0] sample_im;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_re;
        logic signed [OUT_W-1:0] out_im;
        logic                    out_last;
        logic                    out_status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIR_RD,
        ST_MIR_WR,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_SUM,
        ST_BF_WR_E,
        ST_BF_WR_O,
        ST_RD_OUT
    } state_t;

    typedef enum logic {
        PH_LOADING,
        PH_READING
    } phase_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } bf_ctrl_t;

    // Unsigned long division by shift and subtract, for table generation
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q30 sine or cosine by Taylor series, x in Q30 radians in [0, pi/2)
    function automatic longint q30_trig(input longint unsigned x, input bit want_cos);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned d;
        longint          sum;
        x2   = (x * x) >> 30;
        term = want_cos ? (64'd1 << 30) : x;
        sum  = longint'(term);
        for (int i = 1; i <= 14; i++) begin
            d    = want_cos ? longint'(2 * i - 1) * longint'(2 * i)
                            : longint'(2 * i) * longint'(2 * i + 1);
            term = udiv64((term * x2) >> 30, d);
            sum  = (i % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
        end
        return (sum < 0) ? 64'sd0 : sum;
    endfunction

    // Round Q30 to signed Q1.(tw-1), half away from zero, clamp +1.0
    function automatic longint to_twiddle(input longint v, input int unsigned tw);
        int unsigned     sh;
        longint unsigned lim;
        longint unsigned mag;
        sh  = 31 - tw;
        lim = (64'd1 << (tw - 1)) - 64'd1;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        if (mag > lim) mag = lim;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Entry k of a 2^logr-entry cos/sin table
    function automatic logic [31:0] twiddle_val(input int unsigned k, input int unsigned logr,
                                                input int unsigned tw, input bit want_sin);
        int unsigned     q;
        int unsigned     r;
        longint unsigned x;
        longint          c;
        longint          s;
        longint          cv;
        longint          sv;
        q = (k >> (logr - 2)) & 3;
        r = k & ((1 << (logr - 2)) - 1);
        x = ((longint'(r) * 2 * PI_Q30) + (64'd1 << (logr - 1))) >> logr;
        c = q30_trig(x, 1'b1);
        s = q30_trig(x, 1'b0);
        unique case (q)
            0:       begin cv = c;  sv = s;  end
            1:       begin cv = -s; sv = c;  end
            2:       begin cv = -c; sv = -s; end
            default: begin cv = s;  sv = -c; end
        endcase
        return 32'(to_twiddle(want_sin ? sv : cv, tw));
    endfunction

endpackage

### rtl/core/rfft_twrom.sv
// Twiddle cosine/sine ROM with a registered read port.
// Depends on rfft_pkg for the table functions.
module rfft_twrom #(
    parameter int LOGR          = 10,
    parameter int TWIDDLE_WIDTH = 18
) (
    input  logic                            aclk,
    input  logic                            rd_en,
    input  logic [LOGR-1:0]                 addr,
    output logic signed [TWIDDLE_WIDTH-1:0] cos_q,
    output logic signed [TWIDDLE_WIDTH-1:0] sin_q
);
    import rfft_pkg::*;

    localparam int R = 1 << LOGR;

    logic signed [TWIDDLE_WIDTH-1:0] rom_cos [R];
    logic signed [TWIDDLE_WIDTH-1:0] rom_sin [R];
    logic signed [TWIDDLE_WIDTH-1:0] cos_reg;
    logic signed [TWIDDLE_WIDTH-1:0] sin_reg;

    for (genvar k = 0; k < R; k++) begin : g_rom
        localparam logic [31:0] CV = twiddle_val(k, LOGR, TWIDDLE_WIDTH, 1'b0);
        localparam logic [31:0] SV = twiddle_val(k, LOGR, TWIDDLE_WIDTH, 1'b1);
        assign rom_cos[k] = CV[TWIDDLE_WIDTH-1:0];
        assign rom_sin[k] = SV[TWIDDLE_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            cos_reg <= rom_cos[addr];
            sin_reg <= rom_sin[addr];
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

### rtl/core/rfft_bfly.sv
// Radix-2 butterfly datapath: product stage, rounded twiddle sum, saturating add/sub.
// Depends on rfft_pkg for the control struct.
module rfft_bfly #(
    parameter int WORK_WIDTH    = 48,
    parameter int TWIDDLE_WIDTH = 18
) (
    input  logic                            aclk,
    input  rfft_pkg::bf_ctrl_t              ctrl,
    input  logic signed [WORK_WIDTH-1:0]    u_re,
    input  logic signed [WORK_WIDTH-1:0]    u_im,
    input  logic signed [WORK_WIDTH-1:0]    o_re,
    input  logic signed [WORK_WIDTH-1:0]    o_im,
    input  logic signed [TWIDDLE_WIDTH-1:0] w_re,
    input  logic signed [TWIDDLE_WIDTH-1:0] w_im,
    output logic signed [WORK_WIDTH-1:0]    sum_re,
    output logic signed [WORK_WIDTH-1:0]    sum_im,
    output logic signed [WORK_WIDTH-1:0]    dif_re,
    output logic signed [WORK_WIDTH-1:0]    dif_im
);
    import rfft_pkg::*;

    localparam int PW = WORK_WIDTH + TWIDDLE_WIDTH;
    localparam int SW = WORK_WIDTH + TWIDDLE_WIDTH + 2;
    localparam logic signed [SW-1:0] SAT_MAX =
        {{(SW-WORK_WIDTH+1){1'b0}}, {(WORK_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [SW-1:0] RND = SW'(1) << (TWIDDLE_WIDTH - 2);

    function automatic logic signed [WORK_WIDTH-1:0] sat_w(input logic signed [SW-1:0] v);
        if (v > SAT_MAX) return SAT_MAX[WORK_WIDTH-1:0];
        if (v < SAT_MIN) return SAT_MIN[WORK_WIDTH-1:0];
        return v[WORK_WIDTH-1:0];
    endfunction

    logic signed [PW-1:0]         p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [WORK_WIDTH-1:0] u_re_reg, u_im_reg;
    logic signed [WORK_WIDTH-1:0] v_re_reg, v_im_reg;
    logic signed [SW-1:0]         t_re, t_im;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            p_rr_reg <= o_re * w_re;
            p_ii_reg <= o_im * w_im;
            p_ri_reg <= o_re * w_im;
            p_ir_reg <= o_im * w_re;
            u_re_reg <= u_re;
            u_im_reg <= u_im;
        end
        if (ctrl.sum_en) begin
            v_re_reg <= sat_w(t_re);
            v_im_reg <= sat_w(t_im);
        end
    end

    always_comb begin
        t_re = (SW'(p_rr_reg) - SW'(p_ii_reg) + RND) >>> (TWIDDLE_WIDTH - 1);
        t_im = (SW'(p_ri_reg) + SW'(p_ir_reg) + RND) >>> (TWIDDLE_WIDTH - 1);
    end

    assign sum_re = sat_w(SW'(u_re_reg) + SW'(v_re_reg));
    assign sum_im = sat_w(SW'(u_im_reg) + SW'(v_im_reg));
    assign dif_re = sat_w(SW'(u_re_reg) - SW'(v_re_reg));
    assign dif_im = sat_w(SW'(u_im_reg) - SW'(v_im_reg));

endmodule

### rtl/core/real_fft_radix2.sv
// Radix-2 real FFT/IFFT. A read item waits in ST_RD_OUT while the output stalls. The item
// that completes a frame starts the transform: in inverse mode a mirror pass over bins
// n/2+1 to n-1, then (n/2)*log2(n) butterflies (read, multiply, sum, write even, write odd)
// on one shared butterfly unit against a work memory with a single write port; no item
// is taken meanwhile. Samples are written in bit-reversed order, so results come out in
// natural order. The work memory is not cleared by reset.
// Depends on rfft_pkg, rfft_twrom and rfft_bfly.
module real_fft_radix2 #(
    parameter int MAX_POINTS    = 1024,
    parameter int WORK_WIDTH    = 48,
    parameter int TWIDDLE_WIDTH = 18
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [rfft_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rfft_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rfft_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output rfft_pkg::out_item_t                m_data
);
    import rfft_pkg::*;

    localparam int LOGR = $clog2(MAX_POINTS + 1) - 1;
    localparam int R    = 1 << LOGR;
    localparam int CW   = LOGR + 1;
    localparam int BW   = (LOGR > 1) ? LOGR - 1 : 1;
    localparam int DW   = 2 * WORK_WIDTH;
    localparam int SW   = WORK_WIDTH + TWIDDLE_WIDTH + 2;
    localparam int XW   = ((WORK_WIDTH > OUT_W) ? WORK_WIDTH : OUT_W) + 1;
    localparam logic signed [SW-1:0] SAT_MAX =
        {{(SW-WORK_WIDTH+1){1'b0}}, {(WORK_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [XW-1:0] OSAT_MAX = {{(XW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [XW-1:0] OSAT_MIN = ~OSAT_MAX;

    function automatic logic signed [WORK_WIDTH-1:0] sat_w(input logic signed [SW-1:0] v);
        if (v > SAT_MAX) return SAT_MAX[WORK_WIDTH-1:0];
        if (v < SAT_MIN) return SAT_MIN[WORK_WIDTH-1:0];
        return v[WORK_WIDTH-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_o(input logic signed [XW-1:0] v);
        if (v > OSAT_MAX) return OSAT_MAX[OUT_W-1:0];
        if (v < OSAT_MIN) return OSAT_MIN[OUT_W-1:0];
        return v[OUT_W-1:0];
    endfunction

    function automatic logic [LOGR-1:0] bitrev(input logic [LOGR-1:0] a, input logic [3:0] l);
        logic [LOGR-1:0] r;
        for (int i = 0; i < LOGR; i++) r[i] = a[LOGR-1-i];
        return r >> (LOGR - int'(l));
    endfunction

    // control state
    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   load_cnt_reg, load_cnt_next;
    logic [CW-1:0]   read_cnt_reg, read_cnt_next;
    logic            inv_reg, inv_next;
    logic [3:0]      lsize_reg, lsize_next;
    logic [3:0]      stage_reg, stage_next;
    logic [BW-1:0]   bfly_reg, bfly_next;
    logic [LOGR-1:0] mir_reg, mir_next;
    logic            stat_reg, stat_next;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_data_reg, m_data_next;

    // memory ports
    logic [DW-1:0]   mem [R];
    logic            mem_we, rd_a_en, rd_b_en, tw_en;
    logic [LOGR-1:0] mem_wa, rd_a_addr, rd_b_addr, tw_addr;
    logic [DW-1:0]   mem_wd, qa_reg, qb_reg;

    logic [3:0]      lg;
    logic [CW-1:0]   n, need, total, cur;
    logic [LOGR-1:0] half, e_addr, o_addr, k_idx, b_ext;
    logic signed [WORK_WIDTH-1:0] qa_re, qa_im, qb_re, qb_im, shifted;
    logic signed [WORK_WIDTH-1:0] sum_re, sum_im, dif_re, dif_im, in_re, in_im;
    logic signed [TWIDDLE_WIDTH-1:0] tw_cos, tw_sin, w_im;
    bf_ctrl_t        bf_ctrl;
    logic            accept;

    assign lg = (lsize_reg > 4'(LOGR)) ? 4'(LOGR) :
                (lsize_reg < 4'(LOG2_MIN)) ? 4'(LOG2_MIN) : lsize_reg;
    assign n     = CW'(1) << lg;
    assign need  = inv_reg ? (n >> 1) + CW'(1) : n;
    assign total = inv_reg ? n : (n >> 1) + CW'(1);

    // butterfly addressing for stage s: e = group*2^s + k, o = e + 2^(s-1)
    assign half   = LOGR'(1) << (stage_reg - 4'd1);
    assign b_ext  = LOGR'(bfly_reg);
    assign k_idx  = b_ext & (half - LOGR'(1));
    assign e_addr = ((b_ext & ~(half - LOGR'(1))) << 1) | k_idx;
    assign o_addr = e_addr | half;

    assign qa_re = qa_reg[DW-1:WORK_WIDTH];
    assign qa_im = qa_reg[WORK_WIDTH-1:0];
    assign qb_re = qb_reg[DW-1:WORK_WIDTH];
    assign qb_im = qb_reg[WORK_WIDTH-1:0];
    assign in_re = sat_w(SW'(s_data.sample_re));
    assign in_im = sat_w(SW'(s_data.sample_im));
    assign shifted = qa_re >>> lg;
    assign w_im  = inv_reg ? tw_sin : -tw_sin;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    rfft_twrom #(
        .LOGR          (LOGR),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_twrom (
        .aclk  (aclk),
        .rd_en (tw_en),
        .addr  (tw_addr),
        .cos_q (tw_cos),
        .sin_q (tw_sin)
    );

    rfft_bfly #(
        .WORK_WIDTH    (WORK_WIDTH),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_bfly (
        .aclk   (aclk),
        .ctrl   (bf_ctrl),
        .u_re   (qa_re),
        .u_im   (qa_im),
        .o_re   (qb_re),
        .o_im   (qb_im),
        .w_re   (tw_cos),
        .w_im   (w_im),
        .sum_re (sum_re),
        .sum_im (sum_im),
        .dif_re (dif_re),
        .dif_im (dif_im)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (rd_a_en) qa_reg <= mem[rd_a_addr];
        if (rd_b_en) qb_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_LOADING;
            load_cnt_reg <= '0;
            read_cnt_reg <= '0;
            inv_reg      <= 1'b0;
            lsize_reg    <= LOG2_RESET;
            stage_reg    <= 4'd1;
            bfly_reg     <= '0;
            mir_reg      <= '0;
            stat_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            load_cnt_reg <= load_cnt_next;
            read_cnt_reg <= read_cnt_next;
            inv_reg      <= inv_next;
            lsize_reg    <= lsize_next;
            stage_reg    <= stage_next;
            bfly_reg     <= bfly_next;
            mir_reg      <= mir_next;
            stat_reg     <= stat_next;
            m_valid_reg  <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        load_cnt_next = load_cnt_reg;
        read_cnt_next = read_cnt_reg;
        inv_next      = inv_reg;
        lsize_next    = lsize_reg;
        stage_next    = stage_reg;
        bfly_next     = bfly_reg;
        mir_next      = mir_reg;
        stat_next     = stat_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = '0;
        rd_a_en       = 1'b0;
        rd_a_addr     = '0;
        rd_b_en       = 1'b0;
        rd_b_addr     = '0;
        tw_en         = 1'b0;
        tw_addr       = k_idx << (4'(LOGR) - stage_reg);
        bf_ctrl       = '0;
        cur           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.func == FUNC_LOAD) begin
                    cur = (phase_reg != PH_LOADING || load_cnt_reg >= need) ? '0 : load_cnt_reg;
                    phase_next    = PH_LOADING;
                    read_cnt_next = '0;
                    mem_we = 1'b1;
                    mem_wa = bitrev(cur[LOGR-1:0], lg);
                    mem_wd = {in_re, inv_reg ? in_im : WORK_WIDTH'(0)};
                    load_cnt_next = cur + CW'(1);
                    if (cur + CW'(1) == need) begin
                        stage_next = 4'd1;
                        bfly_next  = '0;
                        mir_next   = LOGR'((n >> 1) + CW'(1));
                        state_next = inv_reg ? ST_MIR_RD : ST_BF_RD;
                    end
                end else if (accept) begin
                    stat_next  = (phase_reg != PH_READING);
                    rd_a_en    = 1'b1;
                    rd_a_addr  = read_cnt_reg[LOGR-1:0];
                    state_next = ST_RD_OUT;
                end
            end
            ST_MIR_RD: begin
                rd_a_en    = 1'b1;
                rd_a_addr  = bitrev(LOGR'(n - CW'(mir_reg)), lg);
                state_next = ST_MIR_WR;
            end
            ST_MIR_WR: begin
                // upper bins are conjugates of the lower ones
                mem_we   = 1'b1;
                mem_wa   = bitrev(mir_reg, lg);
                mem_wd   = {qa_re, sat_w(-SW'(qa_im))};
                mir_next = mir_reg + LOGR'(1);
                state_next = (CW'(mir_reg) == n - CW'(1)) ? ST_BF_RD : ST_MIR_RD;
            end
            ST_BF_RD: begin
                rd_a_en    = 1'b1;
                rd_a_addr  = e_addr;
                rd_b_en    = 1'b1;
                rd_b_addr  = o_addr;
                tw_en      = 1'b1;
                state_next = ST_BF_MUL;
            end
            ST_BF_MUL: begin
                bf_ctrl.mul_en = 1'b1;
                state_next     = ST_BF_SUM;
            end
            ST_BF_SUM: begin
                bf_ctrl.sum_en = 1'b1;
                state_next     = ST_BF_WR_E;
            end
            ST_BF_WR_E: begin
                mem_we     = 1'b1;
                mem_wa     = e_addr;
                mem_wd     = {sum_re, sum_im};
                state_next = ST_BF_WR_O;
            end
            ST_BF_WR_O: begin
                mem_we     = 1'b1;
                mem_wa     = o_addr;
                mem_wd     = {dif_re, dif_im};
                state_next = ST_BF_RD;
                if (CW'(bfly_reg) == (n >> 1) - CW'(1)) begin
                    bfly_next = '0;
                    if (stage_reg == lg) begin
                        phase_next    = PH_READING;
                        read_cnt_next = '0;
                        state_next    = ST_IDLE;
                    end else begin
                        stage_next = stage_reg + 4'd1;
                    end
                end else begin
                    bfly_next = bfly_reg + BW'(1);
                end
            end
            ST_RD_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (stat_reg) begin
                        m_data_next = '{out_re: '0, out_im: '0, out_last: 1'b0, out_status: 1'b1};
                    end else begin
                        m_data_next.out_re     = inv_reg ? sat_o(XW'(shifted)) : sat_o(XW'(qa_re));
                        m_data_next.out_im     = inv_reg ? OUT_W'(0) : sat_o(XW'(qa_im));
                        m_data_next.out_last   = (read_cnt_reg + CW'(1) >= total);
                        m_data_next.out_status = 1'b0;
                        if (read_cnt_reg + CW'(1) >= total) begin
                            phase_next    = PH_LOADING;
                            load_cnt_next = '0;
                            read_cnt_next = '0;
                        end else begin
                            read_cnt_next = read_cnt_reg + CW'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cfg_we) begin
            if (cfg_index == CFG_INVERSE_MODE) inv_next = cfg_wdata[0];
            else lsize_next = cfg_wdata;
            phase_next    = PH_LOADING;
            load_cnt_next = '0;
            read_cnt_next = '0;
        end
    end

endmodule

### rtl/core/rfft_chk.sv
// Port-level checker for real_fft_radix2, attached by bind.
// Depends on rfft_pkg for item types and function codes.
module rfft_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input rfft_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input rfft_pkg::out_item_t m_data
);
    import rfft_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_status |->
            m_data.out_re == '0 && m_data.out_im == '0 && !m_data.out_last)
        else $error("empty read carries data");

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_LOAD && !m_valid |=> !m_valid)
        else $error("load item produced a result");

endmodule

bind real_fft_radix2 rfft_chk u_rfft_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
